@@ rtl/core/assert_macros.svh @@
// assertion helpers shared by the core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/core/nprr_pkg.sv @@
package nprr_pkg;

   // parser position
   localparam logic [1:0] POS_FIRST   = 2'd0;
   localparam logic [1:0] POS_SECOND  = 2'd1;
   localparam logic [1:0] POS_LEN     = 2'd2;
   localparam logic [1:0] POS_PAYLOAD = 2'd3;

   // header message type field
   localparam logic [2:0] HDR_DATA = 3'd0;
   localparam logic [2:0] HDR_RSP  = 3'd2;
   localparam logic [2:0] HDR_NTF  = 3'd3;

   // result message type
   localparam logic [1:0] MT_DATA = 2'd0;
   localparam logic [1:0] MT_RSP  = 2'd1;
   localparam logic [1:0] MT_NTF  = 2'd2;

   // error codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_TYPE     = 2'd1;
   localparam logic [1:0] ERR_CONN     = 2'd2;
   localparam logic [1:0] ERR_MISMATCH = 2'd3;

   localparam logic [3:0] GID_MASK = 4'hf;
   localparam logic [5:0] OID_MASK = 6'h3f;

   typedef struct packed {
      logic       wr;
      logic [4:0] limit;
   } cfg_type;

   typedef struct packed {
      logic       valid;
      logic       has_byte;
      logic [7:0] data_byte;
      logic [1:0] msg_type;
      logic [3:0] group_id;
      logic [5:0] opcode_id;
      logic [3:0] conn_id;
      logic       message_end;
      logic [1:0] error_code;
   } result_type;

endpackage

@@ rtl/core/nci_packet_receive_reassembler_core.sv @@
// channel  | direction | handshake             | payload
// ---------+-----------+-----------------------+------------------------------------
// req      | in        | req_tvalid/req_tready | req_tdata: received byte
// rsp      | out       | rsp_tvalid/rsp_tready | rsp_tdata, rsp_tuser, rsp_tlast
// csr      | in        | csr_valid/csr_ready   | csr_data: max_connections
//
// one byte per cycle while req_tready is high; each accepted byte gives zero or one registered item
// the result register is the only stage; req_tready is high whenever it is empty
// or being drained, so a stalled rsp side stops intake only while an item waits
// synchronous active-high reset clears the parser, all pending slots, the result
// valid and sets the connection limit to 1; csr writes are always ready

`include "assert_macros.svh"

module nci_packet_receive_reassembler_core #(
   parameter int CONN_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] rx_byte

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,    // [7:0] data_byte, [11:8] group_id,
                                     // [17:12] opcode_id, [21:18] conn_id,
                                     // [23:22] error_code
   output logic [2:0]  rsp_tuser,    // [0] has_byte, [2:1] msg_type
   output logic        rsp_tlast,    // message_end

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_data      // max_connections
);
   import nprr_pkg::*;

   logic        accept;
   logic [4:0]  limit_ff, limit_in;
   cfg_type     cfg;
   result_type  result;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_data_ff;
   logic [2:0]  rsp_user_ff;
   logic        rsp_last_ff;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   // clamp the written limit to 1..CONN_SLOTS once, at write time
   always_comb begin
      limit_in = limit_ff;
      if (csr_valid) begin
         if (csr_data == 5'd0) begin
            limit_in = 5'd1;
         end else if (csr_data > 5'(CONN_SLOTS)) begin
            limit_in = 5'(CONN_SLOTS);
         end else begin
            limit_in = csr_data;
         end
      end
   end

   assign cfg.wr    = csr_valid;
   assign cfg.limit = limit_in;

   nprr_parse #(
      .CONN_SLOTS(CONN_SLOTS)
   ) u_parse (
      .clock  (clock),
      .reset  (reset),
      .step   (accept),
      .rx_byte(req_tdata),
      .cfg    (cfg),
      .result (result)
   );

   // result register: load on accept, otherwise hold until taken
   always_comb begin
      if (accept) begin
         rsp_valid_in = result.valid;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         limit_ff     <= 5'd1;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         limit_ff     <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && result.valid) begin
         rsp_data_ff <= {result.error_code, result.conn_id, result.opcode_id,
                         result.group_id, result.data_byte};
         rsp_user_ff <= {result.msg_type, result.has_byte};
         rsp_last_ff <= result.message_end;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   // limit stays inside the slot range
   `ASSERT_SAME(a_limit_range, clock, reset, 1'b1, limit_ff != 5'd0 && limit_ff <= 5'(CONN_SLOTS))
   // an error item carries no byte and no message end
   `ASSERT_SAME(a_err_clean, clock, reset, rsp_valid_ff && rsp_data_ff[23:22] != ERR_NONE, !rsp_user_ff[0] && !rsp_last_ff)
   // a waiting item blocks intake
   `ASSERT_SAME(a_stall_blocks, clock, reset, rsp_valid_ff && !rsp_tready, !req_tready)

endmodule

@@ rtl/core/nprr_parse.sv @@
`include "assert_macros.svh"

module nprr_parse #(
   parameter int CONN_SLOTS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           rx_byte,
   input  nprr_pkg::cfg_type    cfg,
   output nprr_pkg::result_type result
);
   import nprr_pkg::*;

   logic [1:0]            pos_ff, pos_in;
   logic [7:0]            hdr_first_ff, hdr_first_in;
   logic [7:0]            hdr_second_ff, hdr_second_in;
   logic [7:0]            left_ff, left_in;
   logic                  fwd_ff, fwd_in;
   logic                  final_ff, final_in;
   logic                  ctl_pend_ff, ctl_pend_in;
   logic [10:0]           ctl_hdr_ff, ctl_hdr_in;
   logic [CONN_SLOTS-1:0] conn_pend_ff, conn_pend_in;

   logic [2:0]  mt;
   logic        pbf;
   logic [3:0]  cid;
   logic [10:0] key;
   logic [7:0]  left_dec;
   logic [1:0]  err;
   logic        emit;
   logic        emit_has;
   logic        emit_end;
   logic        set_slot;
   logic        finish;
   logic        ctl_open;

   assign mt       = hdr_first_ff[7:5];
   assign pbf      = hdr_first_ff[4];
   assign cid      = hdr_first_ff[3:0] & GID_MASK;
   assign key      = {mt[0], cid, hdr_second_ff[5:0] & OID_MASK};
   assign left_dec = left_ff - 8'd1;
   assign ctl_open = step && pos_ff == POS_LEN && err == ERR_NONE && mt != HDR_DATA && pbf;

   always_comb begin
      pos_in        = pos_ff;
      hdr_first_in  = hdr_first_ff;
      hdr_second_in = hdr_second_ff;
      left_in       = left_ff;
      fwd_in        = fwd_ff;
      final_in      = final_ff;
      ctl_pend_in   = ctl_pend_ff;
      ctl_hdr_in    = ctl_hdr_ff;
      conn_pend_in  = conn_pend_ff;
      err           = ERR_NONE;
      emit          = 1'b0;
      emit_has      = 1'b0;
      emit_end      = 1'b0;
      set_slot      = 1'b0;
      finish        = 1'b0;

      if (step) begin
         case (pos_ff)
            POS_FIRST: begin
               hdr_first_in = rx_byte;
               pos_in       = POS_SECOND;
            end
            POS_SECOND: begin
               hdr_second_in = rx_byte;
               pos_in        = POS_LEN;
            end
            POS_LEN: begin
               left_in  = rx_byte;
               fwd_in   = 1'b0;
               final_in = !pbf;
               if (mt == HDR_DATA) begin
                  if ({1'b0, cid} >= cfg.limit) begin
                     err = ERR_CONN;
                  end else begin
                     fwd_in   = 1'b1;
                     set_slot = pbf;
                  end
               end else if (mt == HDR_RSP || mt == HDR_NTF) begin
                  if (ctl_pend_ff && key != ctl_hdr_ff) begin
                     err = ERR_MISMATCH;
                  end else begin
                     fwd_in = 1'b1;
                     if (!ctl_pend_ff && pbf) begin
                        ctl_pend_in = 1'b1;
                        ctl_hdr_in  = key;
                     end
                  end
               end else begin
                  err = ERR_TYPE;
               end
               pos_in = (rx_byte == 8'd0) ? POS_FIRST : POS_PAYLOAD;
               // empty final segment closes the message with a byte-less marker
               if (err == ERR_NONE && rx_byte == 8'd0 && !pbf) begin
                  emit     = 1'b1;
                  emit_end = 1'b1;
                  finish   = 1'b1;
               end
            end
            POS_PAYLOAD: begin
               left_in = left_dec;
               if (left_dec == 8'd0) begin
                  pos_in = POS_FIRST;
               end
               if (fwd_ff) begin
                  emit     = 1'b1;
                  emit_has = 1'b1;
                  emit_end = final_ff && left_dec == 8'd0;
                  finish   = emit_end;
               end
            end
            default: begin
               pos_in = POS_FIRST;
            end
         endcase
      end

      // finishing a control message frees the shared slot
      if (finish && mt != HDR_DATA) begin
         ctl_pend_in = 1'b0;
      end
      for (int i = 0; i < CONN_SLOTS; i++) begin
         if (cid == 4'(i)) begin
            if (set_slot) begin
               conn_pend_in[i] = 1'b1;
            end
            if (finish && mt == HDR_DATA) begin
               conn_pend_in[i] = 1'b0;
            end
         end
         if (cfg.wr && 5'(i) >= cfg.limit) begin
            conn_pend_in[i] = 1'b0;
         end
      end
   end

   always_comb begin
      result = '0;
      if (err != ERR_NONE) begin
         result.valid      = 1'b1;
         result.error_code = err;
      end else if (emit) begin
         result.valid       = 1'b1;
         result.has_byte    = emit_has;
         result.data_byte   = emit_has ? rx_byte : 8'd0;
         result.message_end = emit_end;
         if (mt == HDR_DATA) begin
            result.msg_type = MT_DATA;
            result.conn_id  = cid;
         end else begin
            result.msg_type  = (mt == HDR_RSP) ? MT_RSP : MT_NTF;
            result.group_id  = cid;
            result.opcode_id = hdr_second_ff[5:0] & OID_MASK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= POS_FIRST;
         hdr_first_ff  <= '0;
         hdr_second_ff <= '0;
         left_ff       <= '0;
         fwd_ff        <= 1'b0;
         final_ff      <= 1'b0;
         ctl_pend_ff   <= 1'b0;
         ctl_hdr_ff    <= '0;
         conn_pend_ff  <= '0;
      end else begin
         pos_ff        <= pos_in;
         hdr_first_ff  <= hdr_first_in;
         hdr_second_ff <= hdr_second_in;
         left_ff       <= left_in;
         fwd_ff        <= fwd_in;
         final_ff      <= final_in;
         ctl_pend_ff   <= ctl_pend_in;
         ctl_hdr_ff    <= ctl_hdr_in;
         conn_pend_ff  <= conn_pend_in;
      end
   end

   // payload position always has bytes left to count
   `ASSERT_SAME(a_payload_left, clock, reset, pos_ff == POS_PAYLOAD, left_ff != 8'd0)
   // an accepted non-final control segment leaves the control slot pending
   `ASSERT_NEXT(a_ctl_open, clock, reset, ctl_open, ctl_pend_ff)
   // the first header byte is always followed by the second
   `ASSERT_NEXT(a_first_next, clock, reset, step && pos_ff == POS_FIRST, pos_ff == POS_SECOND)

endmodule
